### rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CHK_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression must never be true outside reset.
`define CHK_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

### rtl/dlarw_pkg.sv
// Package: widths, reset values and codes of the random walker step core.
package dlarw_pkg;

  // Field widths
  localparam int COORD_W = 6;
  localparam int DIR_W   = 2;
  localparam int STEP_W  = 16;
  localparam int CNT_W   = 12;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_START_ROW       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_COL       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PARTICLE_TARGET = 2'd3;

  // Register reset values
  localparam logic [COORD_W-1:0] START_ROW_RST       = 6'd31;
  localparam logic [COORD_W-1:0] START_COL_RST       = 6'd31;
  localparam logic [STEP_W-1:0]  STEP_LIMIT_RST      = 16'd50000;
  localparam logic [CNT_W-1:0]   PARTICLE_TARGET_RST = 12'd163;

  // Move directions
  localparam logic [DIR_W-1:0] DIR_ROW_DN = 2'd0;
  localparam logic [DIR_W-1:0] DIR_ROW_UP = 2'd1;
  localparam logic [DIR_W-1:0] DIR_COL_DN = 2'd2;
  localparam logic [DIR_W-1:0] DIR_COL_UP = 2'd3;

  // Default grid edge length
  localparam int GRID_SIZE_DEF = 64;

endpackage

### rtl/dlarw_ifs.sv
// Channel interfaces: step input, step result and configuration write.

interface dlarw_step_in_if;
  logic                          valid;
  logic                          ready;
  logic [dlarw_pkg::DIR_W-1:0]   direction;
  logic [dlarw_pkg::COORD_W-1:0] respawn_row;
  logic [dlarw_pkg::COORD_W-1:0] respawn_col;

  modport source (output valid, direction, respawn_row, respawn_col, input ready);
  modport sink   (input valid, direction, respawn_row, respawn_col, output ready);
endinterface

interface dlarw_step_out_if;
  logic                          valid;
  logic                          ready;
  logic [dlarw_pkg::COORD_W-1:0] walker_row;
  logic [dlarw_pkg::COORD_W-1:0] walker_col;
  logic                          stuck;
  logic                          abandoned;
  logic [dlarw_pkg::CNT_W-1:0]   stuck_total;
  logic                          done_res;

  modport source (output valid, walker_row, walker_col, stuck, abandoned, stuck_total,
                  done_res, input ready);
  modport sink   (input valid, walker_row, walker_col, stuck, abandoned, stuck_total,
                  done_res, output ready);
endinterface

interface dlarw_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [dlarw_pkg::CFG_IDX_W-1:0]  index;
  logic [dlarw_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/dla_random_walker_step_core.sv
// Top level: one walker step of two-dimensional diffusion-limited aggregation.
//
// The cluster map lives in two row-wide memories, one for even and one for odd
// grid rows, each with two read ports, so the walker's row and both adjacent
// rows are fetched in a single read. Border cells are recognized from their
// coordinates and never stored. An item has its memory read issued at
// acceptance; a decision step then writes back a stuck particle and loads
// the result register, waiting while an untaken result still fills it. The
// next item is taken once the walker position is updated, so the core does
// not accept an item before the previous one has committed. A new item is
// accepted while the previous result still waits. After reset a clearing
// pass loads the empty map and the seed; no item is accepted meanwhile,
// while configuration writes are taken at any time.
module dla_random_walker_step_core #(
  parameter int GRID_SIZE = dlarw_pkg::GRID_SIZE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  dlarw_step_in_if.sink         step_in,
  dlarw_step_out_if.source      step_out,
  dlarw_cfg_if.sink             cfg
);

  // Highest coordinate any access reaches, and the map geometry from it
  localparam int ACC_MAX  = (GRID_SIZE - 1 < 64) ? GRID_SIZE - 1 : 64;
  localparam int CW       = $clog2(ACC_MAX + 1);
  localparam int AW       = CW - 1;
  localparam int WORD_W   = 2 ** CW;
  localparam int ROWS2    = 2 ** AW;
  localparam int HI_INT   = (GRID_SIZE - 2 > 63) ? 63 : GRID_SIZE - 2;
  localparam int MID      = GRID_SIZE / 2 - 1;
  localparam bit SEED_IN  = (MID <= ACC_MAX);
  localparam int SEED_IDX = SEED_IN ? MID : 0;
  localparam logic [dlarw_pkg::COORD_W-1:0] HI = dlarw_pkg::COORD_W'(HI_INT);
  localparam logic [AW-1:0]     SEED_ADDR = AW'(SEED_IDX / 2);
  localparam bit                SEED_ODD  = (SEED_IDX % 2) == 1;
  localparam logic [WORD_W-1:0] SEED_WORD = WORD_W'(1) << SEED_IDX;

  // Clamp a coordinate into the walkable range
  function automatic logic [dlarw_pkg::COORD_W-1:0] sat_coord(
    input logic [dlarw_pkg::COORD_W-1:0] v
  );
    logic [dlarw_pkg::COORD_W-1:0] res;
    if (v == '0) begin
      res = dlarw_pkg::COORD_W'(1);
    end else if (v > HI) begin
      res = HI;
    end else begin
      res = v;
    end
    return res;
  endfunction

  // Configuration registers
  logic [dlarw_pkg::COORD_W-1:0] start_row;
  logic [dlarw_pkg::COORD_W-1:0] start_col;
  logic [dlarw_pkg::STEP_W-1:0]  step_limit;
  logic [dlarw_pkg::CNT_W-1:0]   particle_target;

  // Walker state
  logic [dlarw_pkg::COORD_W-1:0] walker_row;
  logic [dlarw_pkg::COORD_W-1:0] walker_col;
  logic [dlarw_pkg::STEP_W-1:0]  step_count;
  logic [dlarw_pkg::CNT_W-1:0]   stuck_count;

  // Control
  logic          clearing;
  logic [AW-1:0] clr_addr;
  logic          busy;
  logic          accept;
  logic          commit;

  // Captured item
  logic [dlarw_pkg::DIR_W-1:0]   dir_q;
  logic [dlarw_pkg::COORD_W-1:0] rsp_row_q;
  logic [dlarw_pkg::COORD_W-1:0] rsp_col_q;

  // Cluster map memories and their read data
  logic [WORD_W-1:0] mem_even [ROWS2];
  logic [WORD_W-1:0] mem_odd  [ROWS2];
  logic [WORD_W-1:0] even_a, even_b, odd_a, odd_b;
  logic              row_odd_q;

  // Read addresses from the current walker position
  logic [CW-1:0] rw, cw, rw_m1, rw_p1;
  assign rw    = CW'(walker_row);
  assign cw    = CW'(walker_col);
  assign rw_m1 = rw - CW'(1);
  assign rw_p1 = rw + CW'(1);

  assign cfg.ready     = 1'b1;
  assign step_in.ready = !clearing && !busy;
  assign accept        = step_in.valid && step_in.ready;
  assign commit        = busy && (!step_out.valid || step_out.ready);

  // Memory reads, issued at acceptance
  always_ff @(posedge clk) begin
    if (accept) begin
      even_a    <= mem_even[rw[CW-1:1]];
      even_b    <= mem_even[rw_p1[CW-1:1]];
      odd_a     <= mem_odd[rw_m1[CW-1:1]];
      odd_b     <= mem_odd[rw[CW-1:1]];
      row_odd_q <= rw[0];
      dir_q     <= step_in.direction;
      rsp_row_q <= step_in.respawn_row;
      rsp_col_q <= step_in.respawn_col;
    end
  end

  // Rows around the walker
  logic [WORD_W-1:0] row_m, row_0, row_p;
  always_comb begin
    if (row_odd_q) begin
      row_0 = odd_b;
      row_m = even_a;
      row_p = even_b;
    end else begin
      row_0 = even_a;
      row_m = odd_a;
      row_p = odd_b;
    end
  end

  // Step decision
  logic [CW-1:0] cw_m1, cw_p1;
  logic          abandon, nb_cluster, nb_border, own_cluster, do_stick;
  logic [dlarw_pkg::COORD_W-1:0] row_next, col_next;
  logic [dlarw_pkg::STEP_W-1:0]  step_next;
  logic [dlarw_pkg::CNT_W-1:0]   stuck_next;

  assign cw_m1 = cw - CW'(1);
  assign cw_p1 = cw + CW'(1);

  always_comb begin
    abandon     = step_count > step_limit;
    nb_cluster  = row_m[cw] || row_p[cw] || row_0[cw_m1] || row_0[cw_p1];
    nb_border   = (walker_row == dlarw_pkg::COORD_W'(1)) ||
                  (walker_col == dlarw_pkg::COORD_W'(1)) ||
                  (int'(walker_row) == GRID_SIZE - 2) ||
                  (int'(walker_col) == GRID_SIZE - 2);
    own_cluster = row_0[cw];
    do_stick    = !abandon && nb_cluster;
    row_next    = walker_row;
    col_next    = walker_col;
    step_next   = step_count;
    stuck_next  = stuck_count;
    if (abandon) begin
      row_next  = sat_coord(start_row);
      col_next  = sat_coord(start_col);
      step_next = '0;
    end else if (nb_cluster) begin
      row_next  = sat_coord(start_row);
      col_next  = sat_coord(start_col);
      step_next = '0;
      if (stuck_count != '1) begin
        stuck_next = stuck_count + dlarw_pkg::CNT_W'(1);
      end
    end else begin
      if (nb_border || own_cluster) begin
        row_next = sat_coord(rsp_row_q);
        col_next = sat_coord(rsp_col_q);
      end else begin
        case (dir_q)
          dlarw_pkg::DIR_ROW_DN: if (walker_row > dlarw_pkg::COORD_W'(1)) begin
            row_next = walker_row - dlarw_pkg::COORD_W'(1);
          end
          dlarw_pkg::DIR_ROW_UP: if (walker_row < HI) begin
            row_next = walker_row + dlarw_pkg::COORD_W'(1);
          end
          dlarw_pkg::DIR_COL_DN: if (walker_col > dlarw_pkg::COORD_W'(1)) begin
            col_next = walker_col - dlarw_pkg::COORD_W'(1);
          end
          default: if (walker_col < HI) begin
            col_next = walker_col + dlarw_pkg::COORD_W'(1);
          end
        endcase
      end
      if (step_count != '1) begin
        step_next = step_count + dlarw_pkg::STEP_W'(1);
      end
    end
  end

  // Memory write: clearing pass, else a stuck particle into the walker's row
  logic              wr_even, wr_odd;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data_even, wr_data_odd;
  always_comb begin
    if (clearing) begin
      wr_even      = 1'b1;
      wr_odd       = 1'b1;
      wr_addr      = clr_addr;
      wr_data_even = (SEED_IN && !SEED_ODD && clr_addr == SEED_ADDR) ? SEED_WORD : '0;
      wr_data_odd  = (SEED_IN && SEED_ODD && clr_addr == SEED_ADDR) ? SEED_WORD : '0;
    end else begin
      wr_even      = commit && do_stick && !rw[0];
      wr_odd       = commit && do_stick && rw[0];
      wr_addr      = rw[CW-1:1];
      wr_data_even = row_0 | (WORD_W'(1) << cw);
      wr_data_odd  = row_0 | (WORD_W'(1) << cw);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_even) begin
      mem_even[wr_addr] <= wr_data_even;
    end
    if (wr_odd) begin
      mem_odd[wr_addr] <= wr_data_odd;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_row       <= dlarw_pkg::START_ROW_RST;
      start_col       <= dlarw_pkg::START_COL_RST;
      step_limit      <= dlarw_pkg::STEP_LIMIT_RST;
      particle_target <= dlarw_pkg::PARTICLE_TARGET_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        dlarw_pkg::REG_START_ROW:  start_row  <= cfg.data[dlarw_pkg::COORD_W-1:0];
        dlarw_pkg::REG_START_COL:  start_col  <= cfg.data[dlarw_pkg::COORD_W-1:0];
        dlarw_pkg::REG_STEP_LIMIT: step_limit <= cfg.data[dlarw_pkg::STEP_W-1:0];
        default:                   particle_target <= cfg.data[dlarw_pkg::CNT_W-1:0];
      endcase
    end
  end

  // Control, walker state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing       <= 1'b1;
      clr_addr       <= '0;
      busy           <= 1'b0;
      walker_row     <= sat_coord(dlarw_pkg::START_ROW_RST);
      walker_col     <= sat_coord(dlarw_pkg::START_COL_RST);
      step_count     <= '0;
      stuck_count    <= '0;
      step_out.valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == AW'(ROWS2 - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (accept) begin
        busy <= 1'b1;
      end else if (commit) begin
        busy        <= 1'b0;
        walker_row  <= row_next;
        walker_col  <= col_next;
        step_count  <= step_next;
        stuck_count <= stuck_next;
      end
      // result valid: set by a commit, cleared once the result is taken
      if (commit) begin
        step_out.valid <= 1'b1;
      end else if (step_out.valid && step_out.ready) begin
        step_out.valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (commit) begin
      step_out.walker_row  <= row_next;
      step_out.walker_col  <= col_next;
      step_out.stuck       <= do_stick;
      step_out.abandoned   <= abandon;
      step_out.stuck_total <= stuck_next;
      step_out.done_res    <= stuck_next >= particle_target;
    end
  end

endmodule

### rtl/dlarw_checker.sv
// Port-level checker for the random walker step core, with its bind.
`include "assert_macros.svh"

module dlarw_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_stuck,
  input logic                          out_abandoned,
  input logic [dlarw_pkg::CNT_W-1:0]   out_stuck_total,
  input logic [dlarw_pkg::COORD_W-1:0] out_walker_row
);

  // Map clearing holds off items right after reset
  `CHK_ASSERT(a_clear_after_rst, clk, rst, $past(rst) |-> !in_ready, "item taken during clear")

  // An accepted item drops ready, so no two items are taken back to back
  `CHK_ASSERT(a_busy_after_accept, clk, rst, (in_valid && in_ready) |=> !in_ready, "back-to-back accept")

  // A step cannot both stick and be abandoned
  `CHK_NEVER(a_stick_xor_abandon, clk, rst, out_valid && out_stuck && out_abandoned, "stuck and abandoned")

  // A stuck particle leaves a nonzero running total
  `CHK_NEVER(a_stuck_counts, clk, rst, out_valid && out_stuck && out_stuck_total == '0, "stuck not counted")

  // A waiting result holds its position
  `CHK_ASSERT(a_out_hold, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(out_walker_row)), "result dropped")

endmodule

bind dla_random_walker_step_core dlarw_checker u_dlarw_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (step_in.valid),
  .in_ready        (step_in.ready),
  .out_valid       (step_out.valid),
  .out_ready       (step_out.ready),
  .out_stuck       (step_out.stuck),
  .out_abandoned   (step_out.abandoned),
  .out_stuck_total (step_out.stuck_total),
  .out_walker_row  (step_out.walker_row)
);

### tb/sv/tb.sv
// Self-checking testbench for the DLA random walker step core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID             = dlarw_pkg::GRID_SIZE_DEF;
  localparam int COORD_MAX        = (GRID - 2 > 63) ? 63 : GRID - 2;
  localparam int CYCLE_LIMIT      = 3_000_000;
  localparam int TAIL_CYCLES      = 20;
  localparam int HOLD_CYCLES      = 60;
  localparam int RANDOM_PER_PHASE = 165;
  localparam int PLAN_LEN         = 26;

  typedef enum logic [1:0] {CELL_EMPTY, CELL_CLUSTER, CELL_BORDER} cell_e;
  typedef enum logic {ROW_CFG, ROW_STEP} plan_kind_e;

  typedef struct packed {
    logic [dlarw_pkg::DIR_W-1:0]   direction;
    logic [dlarw_pkg::COORD_W-1:0] resp_row;
    logic [dlarw_pkg::COORD_W-1:0] resp_col;
  } step_t;

  typedef struct packed {
    logic [dlarw_pkg::COORD_W-1:0] row;
    logic [dlarw_pkg::COORD_W-1:0] col;
    logic                          stuck;
    logic                          abandoned;
    logic [dlarw_pkg::CNT_W-1:0]   total;
    logic                          done;
  } walk_res_t;

  typedef struct packed {
    plan_kind_e                       kind;
    logic [dlarw_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [dlarw_pkg::CFG_DATA_W-1:0] reg_val;
    step_t                            step;
    logic                             typed;
    walk_res_t                        want;
  } plan_row_t;

  // Directed part: extremes, every direction, respawn, stick, abandon, saturation
  // of start coordinates, done threshold. Expected values typed where obvious.
  localparam plan_row_t DIRECTED_PLAN [0:PLAN_LEN-1] = '{
    // seed under the walker: respawn, coordinates clamped
    '{ROW_STEP, '0, '0, '{dlarw_pkg::DIR_ROW_DN, 6'd0, 6'd63}, 1'b1,
      '{6'd1, 6'd62, 1'b0, 1'b0, 12'd0, 1'b0}},
    // next to the border: respawn
    '{ROW_STEP, '0, '0, '{dlarw_pkg::DIR_COL_UP, 6'd63, 6'd0}, 1'b1,
      '{6'd62, 6'd1, 1'b0, 1'b0, 12'd0, 1'b0}},
    '{ROW_STEP, '0, '0, '{dlarw_pkg::DIR_ROW_UP, 6'd20, 6'd20}, 1'b1,
      '{6'd20, 6'd20, 1'b0, 1'b0, 12'd0, 1'b0}},
    // free moves in all four directions
    '{ROW_STEP, '0, '0, '{dlarw_pkg::DIR_ROW_DN, 6'd42, 6'd21}, 1'b1,
      '{6'd19, 6'd20, 1'b0, 1'b0, 12'd0, 1'b0}},
    '{ROW_STEP, '0, '0, '{dlarw_pkg::DIR_ROW_UP, 6'd21, 6'd42}, 1'b1,
      '{6'd20, 6'd20, 1'b0, 1'b0, 12'd0, 1'b0}},
    '{ROW_STEP, '0, '0, '{dlarw_pkg::DIR_COL_DN, 6'd42, 6'd21}, 1'b1,
      '{6'd20, 6'd19, 1'b0, 1'b0, 12'd0, 1'b0}},
    '{ROW_STEP, '0, '0, '{dlarw_pkg::DIR_COL_UP, 6'd21, 6'd42}, 1'b1,
      '{6'd20, 6'd20, 1'b0, 1'b0, 12'd0, 1'b0}},
    '{ROW_CFG, dlarw_pkg::REG_START_ROW, 16'd30, '0, 1'b0, '0},
    '{ROW_CFG, dlarw_pkg::REG_STEP_LIMIT, 16'd0, '0, 1'b0, '0},
    '{ROW_CFG, dlarw_pkg::REG_PARTICLE_TARGET, 16'd1, '0, 1'b0, '0},
    // over the limit: abandoned, relaunched next to the seed
    '{ROW_STEP, '0, '0, '{dlarw_pkg::DIR_COL_DN, 6'd5, 6'd5}, 1'b1,
      '{6'd30, 6'd31, 1'b0, 1'b1, 12'd0, 1'b0}},
    // sticks, reaches the target
    '{ROW_STEP, '0, '0, '{dlarw_pkg::DIR_COL_UP, 6'd5, 6'd5}, 1'b1,
      '{6'd30, 6'd31, 1'b1, 1'b0, 12'd1, 1'b1}},
    // relaunched on a cluster cell next to the cluster: sticks again
    '{ROW_STEP, '0, '0, '{dlarw_pkg::DIR_ROW_DN, 6'd5, 6'd5}, 1'b1,
      '{6'd30, 6'd31, 1'b1, 1'b0, 12'd2, 1'b1}},
    '{ROW_CFG, dlarw_pkg::REG_START_ROW, 16'd0, '0, 1'b0, '0},
    '{ROW_CFG, dlarw_pkg::REG_START_COL, 16'd63, '0, 1'b0, '0},
    // new start applies to the next launch only, clamped into the grid
    '{ROW_STEP, '0, '0, '{dlarw_pkg::DIR_ROW_UP, 6'd9, 6'd9}, 1'b1,
      '{6'd1, 6'd62, 1'b1, 1'b0, 12'd3, 1'b1}},
    '{ROW_STEP, '0, '0, '{dlarw_pkg::DIR_ROW_DN, 6'd63, 6'd63}, 1'b1,
      '{6'd62, 6'd62, 1'b0, 1'b0, 12'd3, 1'b1}},
    '{ROW_STEP, '0, '0, '{dlarw_pkg::DIR_COL_DN, 6'd9, 6'd9}, 1'b1,
      '{6'd1, 6'd62, 1'b0, 1'b1, 12'd3, 1'b1}},
    '{ROW_CFG, dlarw_pkg::REG_PARTICLE_TARGET, 16'd0, '0, 1'b0, '0},
    '{ROW_CFG, dlarw_pkg::REG_STEP_LIMIT, 16'd65535, '0, 1'b0, '0},
    '{ROW_CFG, dlarw_pkg::REG_START_ROW, 16'd33, '0, 1'b0, '0},
    '{ROW_CFG, dlarw_pkg::REG_START_COL, 16'd31, '0, 1'b0, '0},
    '{ROW_STEP, '0, '0, '{dlarw_pkg::DIR_ROW_UP, 6'd1, 6'd1}, 1'b0, '0},
    '{ROW_STEP, '0, '0, '{dlarw_pkg::DIR_COL_UP, 6'd32, 6'd31}, 1'b0, '0},
    '{ROW_STEP, '0, '0, '{dlarw_pkg::DIR_COL_DN, 6'd0, 6'd0}, 1'b0, '0},
    '{ROW_STEP, '0, '0, '{dlarw_pkg::DIR_ROW_DN, 6'd3, 6'd3}, 1'b0, '0}
  };

  logic clk;
  logic rst;

  dlarw_step_in_if  step_ch();
  dlarw_step_out_if res_ch();
  dlarw_cfg_if      cfg_ch();

  dla_random_walker_step_core dut (
    .clk      (clk),
    .rst      (rst),
    .step_in  (step_ch),
    .step_out (res_ch),
    .cfg      (cfg_ch)
  );

  // Walker model state
  cell_e                         grid_map [0:GRID-1][0:GRID-1];
  logic [dlarw_pkg::COORD_W-1:0] pos_row;
  logic [dlarw_pkg::COORD_W-1:0] pos_col;
  logic [dlarw_pkg::STEP_W-1:0]  steps_taken;
  logic [dlarw_pkg::CNT_W-1:0]   stuck_sum;
  logic [dlarw_pkg::COORD_W-1:0] cfg_row;
  logic [dlarw_pkg::COORD_W-1:0] cfg_col;
  logic [dlarw_pkg::STEP_W-1:0]  cfg_limit;
  logic [dlarw_pkg::CNT_W-1:0]   cfg_target;

  walk_res_t pending_walks [$];
  walk_res_t head_walk;
  int        fail_count;
  int        cycle_count;
  bit        steady;
  bit        hold_req;
  int        hold_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [dlarw_pkg::COORD_W-1:0] clamp_coord(
    input logic [dlarw_pkg::COORD_W-1:0] v
  );
    if (v < 1) return dlarw_pkg::COORD_W'(1);
    if (v > COORD_MAX) return dlarw_pkg::COORD_W'(COORD_MAX);
    return v;
  endfunction

  function automatic bit touches(input int r, input int c, input cell_e kind);
    return grid_map[r][c+1] == kind || grid_map[r][c-1] == kind ||
           grid_map[r+1][c] == kind || grid_map[r-1][c] == kind;
  endfunction

  function automatic void relaunch();
    pos_row     = clamp_coord(cfg_row);
    pos_col     = clamp_coord(cfg_col);
    steps_taken = '0;
  endfunction

  // Grid, registers and walker as they stand after reset
  function automatic void reset_walk_model();
    for (int r = 0; r < GRID; r++)
      for (int c = 0; c < GRID; c++)
        grid_map[r][c] = (r == 0 || c == 0 || r == GRID - 1 || c == GRID - 1) ?
                         CELL_BORDER : CELL_EMPTY;
    grid_map[GRID/2-1][GRID/2-1] = CELL_CLUSTER;
    cfg_row    = dlarw_pkg::START_ROW_RST;
    cfg_col    = dlarw_pkg::START_COL_RST;
    cfg_limit  = dlarw_pkg::STEP_LIMIT_RST;
    cfg_target = dlarw_pkg::PARTICLE_TARGET_RST;
    stuck_sum  = '0;
    relaunch();
  endfunction

  // One walker step: abandon, stick, respawn or move
  function automatic walk_res_t advance_walker(input step_t s);
    walk_res_t res;
    int        row;
    int        col;
    row           = pos_row;
    col           = pos_col;
    res.stuck     = 1'b0;
    res.abandoned = 1'b0;
    if (steps_taken > cfg_limit) begin
      res.abandoned = 1'b1;
      relaunch();
    end else if (touches(row, col, CELL_CLUSTER)) begin
      grid_map[row][col] = CELL_CLUSTER;
      res.stuck = 1'b1;
      if (stuck_sum != '1) stuck_sum++;
      relaunch();
    end else begin
      if (touches(row, col, CELL_BORDER) || grid_map[row][col] == CELL_CLUSTER) begin
        pos_row = clamp_coord(s.resp_row);
        pos_col = clamp_coord(s.resp_col);
      end else begin
        case (s.direction)
          dlarw_pkg::DIR_ROW_DN: if (row > 1) pos_row = pos_row - 1'b1;
          dlarw_pkg::DIR_ROW_UP: if (row < COORD_MAX) pos_row = pos_row + 1'b1;
          dlarw_pkg::DIR_COL_DN: if (col > 1) pos_col = pos_col - 1'b1;
          dlarw_pkg::DIR_COL_UP: if (col < COORD_MAX) pos_col = pos_col + 1'b1;
        endcase
      end
      if (steps_taken != '1) steps_taken++;
    end
    res.row   = pos_row;
    res.col   = pos_col;
    res.total = stuck_sum;
    res.done  = stuck_sum >= cfg_target;
    return res;
  endfunction

  // Respawn points mostly near the cluster so walkers stick often
  function automatic step_t random_step(input bit corner_only);
    step_t       s;
    int unsigned pick;
    s.direction = dlarw_pkg::DIR_W'($urandom_range(0, 3));
    pick        = $urandom_range(0, 99);
    if (corner_only) begin
      s.resp_row = dlarw_pkg::COORD_W'($urandom_range(0, 1));
      s.resp_col = dlarw_pkg::COORD_W'($urandom_range(0, 1));
    end else if (pick < 70) begin
      s.resp_row = dlarw_pkg::COORD_W'($urandom_range(25, 37));
      s.resp_col = dlarw_pkg::COORD_W'($urandom_range(25, 37));
    end else if (pick < 90) begin
      s.resp_row = dlarw_pkg::COORD_W'($urandom_range(0, 63));
      s.resp_col = dlarw_pkg::COORD_W'($urandom_range(0, 63));
    end else begin
      s.resp_row = $urandom_range(0, 1) ? 6'd63 - 6'($urandom_range(0, 1))
                                        : 6'($urandom_range(0, 1));
      s.resp_col = $urandom_range(0, 1) ? 6'd63 - 6'($urandom_range(0, 1))
                                        : 6'($urandom_range(0, 1));
    end
    return s;
  endfunction

  // Offer one item; the expectation is queued when it is accepted
  task automatic send_step(input step_t s, input logic typed, input walk_res_t want);
    walk_res_t predicted;
    cfg_ch.valid <= 1'b0;
    if (!steady && $urandom_range(0, 99) < 10) begin
      step_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    step_ch.valid       <= 1'b1;
    step_ch.direction   <= s.direction;
    step_ch.respawn_row <= s.resp_row;
    step_ch.respawn_col <= s.resp_col;
    @(posedge clk);
    while (step_ch.ready !== 1'b1) @(posedge clk);
    predicted = advance_walker(s);
    pending_walks.push_back(typed ? want : predicted);
  endtask

  // Register write, only once every pending result has come back
  task automatic write_reg(input logic [dlarw_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dlarw_pkg::CFG_DATA_W-1:0] val);
    step_ch.valid <= 1'b0;
    while (pending_walks.size() != 0) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    case (idx)
      dlarw_pkg::REG_START_ROW:       cfg_row    = val[dlarw_pkg::COORD_W-1:0];
      dlarw_pkg::REG_START_COL:       cfg_col    = val[dlarw_pkg::COORD_W-1:0];
      dlarw_pkg::REG_STEP_LIMIT:      cfg_limit  = val[dlarw_pkg::STEP_W-1:0];
      dlarw_pkg::REG_PARTICLE_TARGET: cfg_target = val[dlarw_pkg::CNT_W-1:0];
    endcase
  endtask

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      fail_count++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // Result receiver: random stalls, long hold-off on request
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= steady || ($urandom_range(0, 99) >= 10);
      end
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (pending_walks.size() == 0) begin
        fail_count++;
        $error("result with no step pending");
      end else begin
        head_walk = pending_walks.pop_front();
        check_field("walker_row", 16'(head_walk.row), 16'(res_ch.walker_row));
        check_field("walker_col", 16'(head_walk.col), 16'(res_ch.walker_col));
        check_field("stuck", 16'(head_walk.stuck), 16'(res_ch.stuck));
        check_field("abandoned", 16'(head_walk.abandoned), 16'(res_ch.abandoned));
        check_field("stuck_total", 16'(head_walk.total), 16'(res_ch.stuck_total));
        check_field("done_res", 16'(head_walk.done), 16'(res_ch.done_res));
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("dla_random_walker_step_core test failed");
    $finish;
  end

  initial begin
    rst                 = 1'b1;
    fail_count          = 0;
    steady              = 1'b0;
    hold_req            = 1'b0;
    hold_left           = 0;
    step_ch.valid       = 1'b0;
    step_ch.direction   = '0;
    step_ch.respawn_row = '0;
    step_ch.respawn_col = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = '0;
    cfg_ch.data         = '0;
    reset_walk_model();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < PLAN_LEN; i++) begin
      if (DIRECTED_PLAN[i].kind == ROW_CFG)
        write_reg(DIRECTED_PLAN[i].reg_idx, DIRECTED_PLAN[i].reg_val);
      else
        send_step(DIRECTED_PLAN[i].step, DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);
    end

    // random phases: start near the cluster or at the extremes, limits and
    // targets across their range; junk in the unused data bits
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(dlarw_pkg::REG_START_ROW, (ph == 1) ? 16'hFFFF
                : {10'($urandom), 6'($urandom_range(27, 35))});
      write_reg(dlarw_pkg::REG_START_COL, (ph == 1) ? 16'hFFC0
                : {10'($urandom), 6'($urandom_range(27, 35))});
      write_reg(dlarw_pkg::REG_STEP_LIMIT, (ph == 0) ? 16'($urandom_range(20, 300)) :
                                           (ph == 1) ? 16'hFFFF :
                                           (ph == 2) ? 16'd0 :
                                           (ph == 3) ? 16'd1000 : 16'($urandom));
      write_reg(dlarw_pkg::REG_PARTICLE_TARGET, (ph == 1) ? 16'h0FFF
                : {4'($urandom), 12'($urandom_range(0, 60))});
      steady = (ph == 3);
      if (ph == 2) hold_req = 1'b1;
      repeat (RANDOM_PER_PHASE) send_step(random_step(1'b0), 1'b0, '0);
    end
    steady = 1'b0;

    // park the walker in a corner where it respawns in place, first under
    // the limit zero, then the largest limit, then just below it
    write_reg(dlarw_pkg::REG_START_ROW, 16'hFFC0);
    write_reg(dlarw_pkg::REG_START_COL, 16'h0000);
    write_reg(dlarw_pkg::REG_STEP_LIMIT, 16'd0);
    repeat (3) send_step(random_step(1'b1), 1'b0, '0);
    write_reg(dlarw_pkg::REG_STEP_LIMIT, 16'hFFFF);
    repeat (8) send_step(random_step(1'b1), 1'b0, '0);
    write_reg(dlarw_pkg::REG_STEP_LIMIT, 16'hFFFE);
    repeat (3) send_step(random_step(1'b1), 1'b0, '0);

    // drain
    step_ch.valid <= 1'b0;
    cfg_ch.valid  <= 1'b0;
    while (pending_walks.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("dla_random_walker_step_core test passed");
    else
      $display("dla_random_walker_step_core test failed");
    $finish;
  end

endmodule
